// ----- hw/rtl/bfo_pkg.sv -----
`default_nettype none

package bfo_pkg;

    // Stage count default and the depth of the arctangent table
    localparam int unsigned CORDIC_STAGES_DEF = 16;
    localparam int unsigned ATAN_LEN          = 24;

    // Field widths
    localparam int unsigned POS_W   = 32;
    localparam int unsigned YAW_W   = 16;
    localparam int unsigned DIFF_W  = POS_W + 2;   // difference, room for negation
    localparam int unsigned ACC_W   = 64;          // Q28 rotation datapath
    localparam int unsigned ZACC_W  = 34;          // angle accumulator, 2^32 per turn
    localparam int unsigned ANG_W   = YAW_W + 1;
    localparam int unsigned FRAC_W  = 28;
    localparam int unsigned GAIN_W  = 29;
    localparam int unsigned RES_W   = ACC_W - FRAC_W;

    localparam logic signed [GAIN_W-1:0] GAIN_Q28 = 29'sh09B74EDA;
    localparam logic signed [ACC_W-1:0]  HALF_LSB = 64'sh0000_0000_0800_0000;

    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 17'sd16384;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 17'sd32768;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [ACC_W-1:0]  x;
        logic signed [ACC_W-1:0]  y;
        logic signed [ZACC_W-1:0] z;
    } bfo_vec_t;

    // atan(2^-i), 2^32 per turn, truncated
    function automatic logic [31:0] bfo_atan(input int unsigned idx);
        logic [31:0] t;
        unique case (idx)
            0:  t = 32'h20000000;
            1:  t = 32'h12E4051D;
            2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;
            5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;
            7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2E;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2F9;
            15: t = 32'h0000517C;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A2F;
            19: t = 32'h00000517;
            20: t = 32'h0000028B;
            21: t = 32'h00000145;
            22: t = 32'h000000A2;
            23: t = 32'h00000051;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bfo_prep.sv -----
`default_nettype none

// Two stages: difference, half-turn fold and angle setup; then gain multiply.
module bfo_prep (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [bfo_pkg::POS_W-1:0]    base_x,
    input  wire logic [bfo_pkg::POS_W-1:0]    base_y,
    input  wire logic [bfo_pkg::YAW_W-1:0]    base_yaw,
    input  wire logic [bfo_pkg::POS_W-1:0]    point_x,
    input  wire logic [bfo_pkg::POS_W-1:0]    point_y,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output bfo_pkg::bfo_vec_t                 out_vec
);
    import bfo_pkg::*;

    logic                     a_valid_reg;
    logic signed [DIFF_W-1:0] dx_reg, dx_next;
    logic signed [DIFF_W-1:0] dy_reg, dy_next;
    logic signed [ZACC_W-1:0] z_reg, z_next;
    logic                     a_ready;

    logic                     b_valid_reg;
    bfo_vec_t                 vec_reg, vec_next;

    logic signed [DIFF_W-1:0] dx_raw, dy_raw;
    logic signed [ANG_W-1:0]  ang, ang_fold;
    logic                     flip;
    logic signed [ACC_W-2:0]  px, py;

    // stage A
    always_comb begin
        dx_raw = DIFF_W'(signed'(point_x)) - DIFF_W'(signed'(base_x));
        dy_raw = DIFF_W'(signed'(point_y)) - DIFF_W'(signed'(base_y));
        ang    = -ANG_W'(signed'(base_yaw));
        flip   = (ang > QUARTER_TURN) || (ang < -QUARTER_TURN);
        if (!flip) begin
            ang_fold = ang;
        end else if (ang > 0) begin
            ang_fold = ang - HALF_TURN;
        end else begin
            ang_fold = ang + HALF_TURN;
        end
        dx_next = flip ? -dx_raw : dx_raw;
        dy_next = flip ? -dy_raw : dy_raw;
        z_next  = {{(ZACC_W-ANG_W-16){ang_fold[ANG_W-1]}}, ang_fold, 16'h0000};
    end

    assign a_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (in_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            z_reg  <= z_next;
        end
    end

    // stage B: gain compensation, Q28
    assign px = (ACC_W-1)'(dx_reg) * (ACC_W-1)'(GAIN_Q28);
    assign py = (ACC_W-1)'(dy_reg) * (ACC_W-1)'(GAIN_Q28);

    always_comb begin
        vec_next.x = ACC_W'(px);
        vec_next.y = ACC_W'(py);
        vec_next.z = z_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && a_valid_reg) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bfo_rot_stage.sv -----
`default_nettype none

// One CORDIC micro-rotation, registered.
module bfo_rot_stage #(
    parameter int unsigned IDX = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bfo_pkg::bfo_vec_t in_vec,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bfo_pkg::bfo_vec_t      out_vec
);
    import bfo_pkg::*;

    localparam logic signed [ZACC_W-1:0] ANGLE = ZACC_W'(bfo_atan(IDX));

    logic                    valid_reg;
    bfo_vec_t                vec_reg, vec_next;
    logic signed [ACC_W-1:0] xs, ys;

    always_comb begin
        xs = in_vec.x >>> IDX;
        ys = in_vec.y >>> IDX;
        if (!in_vec.z[ZACC_W-1]) begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - ANGLE;
        end else begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + ANGLE;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bfo_round.sv -----
`default_nettype none

// Round half up out of Q28, clip to 32 bits; this is the output register.
module bfo_round (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire bfo_pkg::bfo_vec_t         in_vec,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [bfo_pkg::POS_W-1:0]      longitudinal,
    output logic [bfo_pkg::POS_W-1:0]      lateral,
    output logic                           saturated
);
    import bfo_pkg::*;

    logic                    valid_reg;
    logic [POS_W-1:0]        lon_reg, lon_next;
    logic [POS_W-1:0]        lat_reg, lat_next;
    logic                    sat_reg, sat_next;
    logic signed [ACC_W-1:0] sx, sy;
    logic signed [RES_W-1:0] rx, ry;
    logic                    ovx, ovy;

    always_comb begin
        sx  = in_vec.x + HALF_LSB;
        sy  = in_vec.y + HALF_LSB;
        rx  = sx[ACC_W-1:FRAC_W];
        ry  = sy[ACC_W-1:FRAC_W];
        // out of range when the bits above the result are not a sign extension
        ovx = (rx[RES_W-1:POS_W-1] != {(RES_W-POS_W+1){rx[RES_W-1]}});
        ovy = (ry[RES_W-1:POS_W-1] != {(RES_W-POS_W+1){ry[RES_W-1]}});
        lon_next = ovx ? (rx[RES_W-1] ? POS_MIN : POS_MAX) : rx[POS_W-1:0];
        lat_next = ovy ? (ry[RES_W-1] ? POS_MIN : POS_MAX) : ry[POS_W-1:0];
        sat_next = ovx || ovy;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            lon_reg <= lon_next;
            lat_reg <= lat_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid    = valid_reg;
    assign longitudinal = lon_reg;
    assign lateral      = lat_reg;
    assign saturated    = sat_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/body_frame_offset.sv -----
// Registers from input transfer to result valid: difference/fold, gain multiply,
// one per micro-rotation (CORDIC_STAGES, capped at 24), and round/clip.
// Throughput: one transfer per cycle on both sides while m_tready is high;
// every stage has its own valid bit and a stall only holds stages that are occupied.
// Reset (aresetn low, synchronous) clears all valid bits; data registers keep X.
`default_nettype none

module body_frame_offset #(
    parameter int unsigned CORDIC_STAGES = bfo_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input pose query
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] base_x, [63:32] base_y, [79:64] base_yaw,
    // [111:80] point_x, [143:112] point_y
    input  wire logic [143:0] s_tdata,
    // result
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] longitudinal, [63:32] lateral
    output logic [63:0]       m_tdata,
    // [0] saturated
    output logic [0:0]        m_tuser
);
    import bfo_pkg::*;

    // the angle table has 24 entries; more stages would add nothing
    localparam int unsigned NSTG = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    // stage k of the chain feeds rotation k; stage NSTG feeds rounding
    logic     stg_valid [0:NSTG];
    logic     stg_ready [0:NSTG];
    bfo_vec_t stg_vec   [0:NSTG];

    logic [POS_W-1:0] lon, lat;
    logic             sat;

    bfo_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .base_x    (s_tdata[31:0]),
        .base_y    (s_tdata[63:32]),
        .base_yaw  (s_tdata[79:64]),
        .point_x   (s_tdata[111:80]),
        .point_y   (s_tdata[143:112]),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_vec   (stg_vec[0])
    );

    // one registered micro-rotation per CORDIC iteration
    for (genvar k = 0; k < NSTG; k++) begin : g_rot
        bfo_rot_stage #(
            .IDX (k)
        ) u_rot (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_vec    (stg_vec[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_vec   (stg_vec[k+1])
        );
    end

    // round, clip, and hold the result until the transfer completes
    bfo_round u_round (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (stg_valid[NSTG]),
        .in_ready     (stg_ready[NSTG]),
        .in_vec       (stg_vec[NSTG]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .longitudinal (lon),
        .lateral      (lat),
        .saturated    (sat)
    );

    assign m_tdata = {lat, lon};
    assign m_tuser = sat;

endmodule

`default_nettype wire

// ----- hw/rtl/bfo_checker.sv -----
`default_nettype none

module bfo_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [0:0]  m_tuser
);
    import bfo_pkg::*;

    // a pending result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result does not change
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // with the output register empty nothing can hold the input side
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a clipped result carries a bound in at least one offset
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[31:0] == POS_MAX) || (m_tdata[31:0] == POS_MIN) ||
            (m_tdata[63:32] == POS_MAX) || (m_tdata[63:32] == POS_MIN))
        else $error("saturation flag without clipped offset");

endmodule

bind body_frame_offset bfo_checker u_bfo_checker (.*);

`default_nettype wire
